// ===== hdl/temp_jump_filter_with_publish_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the temperature jump filter
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEMP_JUMP_FILTER_WITH_PUBLISH_MACROS_SVH
`define TEMP_JUMP_FILTER_WITH_PUBLISH_MACROS_SVH

`ifndef SYNTHESIS

`define TJF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tjf assertion failed");

`define TJF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tjf assertion failed");

`else

`define TJF_ASSERT_SAME(label, ante, cons)

`define TJF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/tjf_pkg.sv =====
// ----------------------------------------------------------------------------
// Temperature jump filter package
// Item layouts, held state, configuration registers and helpers.
// ----------------------------------------------------------------------------
package tjf_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [TIME_W-1:0]        ms_t;
  typedef logic [LIMIT_W-1:0]       limit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_THRESHOLD = 8'd0,
    REG_STABLE_BAND    = 8'd1,
    REG_SETTLE_MS      = 8'd2,
    REG_HEARTBEAT_MS   = 8'd3
  } cfg_reg_e;

  localparam limit_t JUMP_THRESHOLD_RST = 11'd50;
  localparam limit_t STABLE_BAND_RST    = 11'd5;
  localparam ms_t    SETTLE_MS_RST      = 32'd60000;
  localparam ms_t    HEARTBEAT_MS_RST   = 32'd300000;

  // first field in the highest bits
  typedef struct packed {
    logic [1:0] pad;
    logic       high_range;
    logic       rest_on;
    logic       heater_on;
    temp_t      meas_temp;
    logic       meas_valid;
    temp_t      target_temp;
    logic       set_valid;
    ms_t        now_ms;
    logic       link_alive;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pad;
    logic       shown_high_range;
    logic       shown_rest;
    logic       shown_heating;
    temp_t      shown_meas_temp;
    logic       shown_meas_valid;
    temp_t      shown_target_temp;
    logic       shown_set_valid;
    logic       publish;
  } out_item_t;

  typedef struct packed {
    limit_t jump_threshold;
    limit_t stable_band;
    ms_t    settle_ms;
    ms_t    heartbeat_ms;
  } cfg_t;

  typedef struct packed {
    temp_t      target;
    logic       target_valid;
    temp_t      baseline;
    logic       baseline_valid;
    temp_t      pending;
    logic       pending_valid;
    ms_t        pending_since;
    ms_t        last_publish;
    logic [2:0] flags;
    logic       ever_published;
  } state_t;

  function automatic logic [TEMP_W:0] abs_diff(input temp_t a, input temp_t b);
    logic [TEMP_W:0] d;
    d = {a[TEMP_W-1], a} - {b[TEMP_W-1], b};
    return d[TEMP_W] ? (~d + 13'd1) : d;
  endfunction

endpackage

// ===== hdl/tjf_decide.sv =====
// ----------------------------------------------------------------------------
// Temperature jump filter decision logic
// Next held state and result for one report, in a single combinational pass.
// ----------------------------------------------------------------------------
module tjf_decide (
  input  tjf_pkg::state_t    state_i,
  input  tjf_pkg::in_item_t  item_i,
  input  tjf_pkg::cfg_t      cfg_i,
  output tjf_pkg::state_t    state_o,
  output tjf_pkg::out_item_t result_o
);
  import tjf_pkg::*;

  logic [TEMP_W:0] base_dev;
  logic [TEMP_W:0] pend_dev;
  ms_t             pend_age;
  ms_t             pub_age;
  logic [2:0]      flags;
  logic            pub;
  state_t          nxt;

  assign base_dev = abs_diff(item_i.meas_temp, state_i.baseline);
  assign pend_dev = abs_diff(item_i.meas_temp, state_i.pending);
  assign pend_age = item_i.now_ms - state_i.pending_since;
  assign pub_age  = item_i.now_ms - state_i.last_publish;
  assign flags    = {item_i.high_range, item_i.rest_on, item_i.heater_on};

  always_comb begin
    nxt = state_i;
    pub = 1'b0;
    if (!item_i.link_alive) begin
      nxt.target         = '0;
      nxt.target_valid   = 1'b0;
      nxt.baseline       = '0;
      nxt.baseline_valid = 1'b0;
      nxt.pending        = '0;
      nxt.pending_valid  = 1'b0;
    end else begin
      if (item_i.set_valid) begin
        if (state_i.target_valid && (item_i.target_temp != state_i.target)) begin
          pub = 1'b1;
        end
        nxt.target       = item_i.target_temp;
        nxt.target_valid = 1'b1;
      end

      if (item_i.meas_valid) begin
        if (!state_i.baseline_valid) begin
          nxt.baseline       = item_i.meas_temp;
          nxt.baseline_valid = 1'b1;
        end else if (base_dev > {2'b00, cfg_i.jump_threshold}) begin
          if (!state_i.pending_valid || (pend_dev > {2'b00, cfg_i.stable_band})) begin
            nxt.pending       = item_i.meas_temp;
            nxt.pending_valid = 1'b1;
            nxt.pending_since = item_i.now_ms;
          end else if (pend_age > cfg_i.settle_ms) begin
            if (item_i.meas_temp != state_i.baseline) begin
              pub = 1'b1;
            end
            nxt.baseline      = item_i.meas_temp;
            nxt.pending       = '0;
            nxt.pending_valid = 1'b0;
          end
        end else begin
          if (item_i.meas_temp != state_i.baseline) begin
            pub = 1'b1;
          end
          nxt.baseline      = item_i.meas_temp;
          nxt.pending       = '0;
          nxt.pending_valid = 1'b0;
        end
      end

      if (flags != state_i.flags) begin
        pub = 1'b1;
      end
      nxt.flags = flags;

      if (!state_i.ever_published || (pub_age > cfg_i.heartbeat_ms)) begin
        pub = 1'b1;
      end

      if (pub) begin
        nxt.last_publish   = item_i.now_ms;
        nxt.ever_published = 1'b1;
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o                   = '0;
    result_o.publish           = pub;
    result_o.shown_set_valid   = nxt.target_valid;
    result_o.shown_target_temp = nxt.target;
    result_o.shown_meas_valid  = nxt.baseline_valid;
    result_o.shown_meas_temp   = nxt.baseline;
    result_o.shown_heating     = nxt.flags[0];
    result_o.shown_rest        = nxt.flags[1];
    result_o.shown_high_range  = nxt.flags[2];
  end

endmodule

// ===== hdl/temp_jump_filter_with_publish.sv =====
// ----------------------------------------------------------------------------
// Temperature jump filter with publish decision
// One result per status report; takes one report per clock cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Each report is captured in an input register and, when the output register
// can advance, its result lands there while the held state is updated at the
// same edge, so the following report already sees it. The result is read from
// the output register; throughput is one report per cycle, limited only by the
// downstream tready.
// Configuration is taken whenever cfg_valid_i is high.
module temp_jump_filter_with_publish (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tjf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // link_alive, now_ms[32], set_valid, target_temp[12], meas_valid, meas_temp[12],
  // heater_on, rest_on, high_range, zero pad[2]
  input  tjf_pkg::in_item_t                s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // publish, shown_set_valid, shown_target_temp[12], shown_meas_valid,
  // shown_meas_temp[12], shown_heating, shown_rest, shown_high_range, zero pad[2]
  output tjf_pkg::out_item_t               m_axis_tdata
);
  import tjf_pkg::*;

  `include "temp_jump_filter_with_publish_macros.svh"

  cfg_t      cfg_q;
  state_t    state_q;
  state_t    state_d;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      out_valid_q;
  logic      advance;
  logic      fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RST;
      cfg_q.stable_band    <= STABLE_BAND_RST;
      cfg_q.settle_ms      <= SETTLE_MS_RST;
      cfg_q.heartbeat_ms   <= HEARTBEAT_MS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg_data_i[LIMIT_W-1:0];
        REG_STABLE_BAND:    cfg_q.stable_band    <= cfg_data_i[LIMIT_W-1:0];
        REG_SETTLE_MS:      cfg_q.settle_ms      <= cfg_data_i;
        REG_HEARTBEAT_MS:   cfg_q.heartbeat_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
  end

  tjf_decide u_decide (
    .state_i  (state_q),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `TJF_ASSERT_SAME(a_pending_needs_baseline, state_q.pending_valid, state_q.baseline_valid)
  `TJF_ASSERT_NEXT(a_link_down_quiet, fire && !in_q.link_alive,
                   !out_q.publish && !out_q.shown_meas_valid && !out_q.shown_set_valid)
  `TJF_ASSERT_NEXT(a_publish_stamps_time, fire && result.publish,
                   state_q.last_publish == $past(in_q.now_ms))
  `TJF_ASSERT_NEXT(a_link_up_published, fire && in_q.link_alive, state_q.ever_published)
  `TJF_ASSERT_NEXT(a_stalled_item_kept, in_valid_q && !advance, in_valid_q && $stable(state_q))

endmodule

// ===== sim/temp_jump_filter_with_publish_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature jump filter with publish decision: testbench
// Drives status reports into the stream input and predicts each result:
// the held target, the filtered baseline with pending jumps, the flags and
// the publish decision. Every result is checked field by field in order.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module temp_jump_filter_with_publish_tb;
  import tjf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  in_item_t             s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  out_item_t            m_axis_tdata;

  cfg_t      regs;
  state_t    held;
  out_item_t shown_q[$];
  logic      idle_on = 1'b1;
  ms_t       clock_ms = '0;
  int        mismatches = 0;
  int        n_reports = 0;
  int        n_results = 0;
  int        n_published = 0;
  int        n_writes = 0;
  int        quiet = 0;

  temp_jump_filter_with_publish i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 15);
  end

  function automatic int temp_gap(input temp_t a, input temp_t b);
    int ia;
    int ib;
    ia = a;
    ib = b;
    return (ia > ib) ? ia - ib : ib - ia;
  endfunction

  function automatic int bound_temp(input int v);
    return (v < -1000) ? -1000 : ((v > 2000) ? 2000 : v);
  endfunction

  function automatic logic take_baseline(input temp_t t);
    logic changed;
    changed = (t != held.baseline);
    held.baseline      = t;
    held.pending       = '0;
    held.pending_valid = 1'b0;
    return changed;
  endfunction

  function automatic out_item_t predict_report(input in_item_t r);
    out_item_t  o;
    logic       pub;
    logic [2:0] fl;
    ms_t        elapsed;
    pub = 1'b0;
    fl  = {r.high_range, r.rest_on, r.heater_on};
    if (!r.link_alive) begin
      held.target         = '0;
      held.target_valid   = 1'b0;
      held.baseline       = '0;
      held.baseline_valid = 1'b0;
      held.pending        = '0;
      held.pending_valid  = 1'b0;
    end else begin
      if (r.set_valid) begin
        if (held.target_valid && r.target_temp != held.target) pub = 1'b1;
        held.target       = r.target_temp;
        held.target_valid = 1'b1;
      end
      if (r.meas_valid) begin
        if (!held.baseline_valid) begin
          held.baseline       = r.meas_temp;
          held.baseline_valid = 1'b1;
        end else if (temp_gap(r.meas_temp, held.baseline) > int'(regs.jump_threshold)) begin
          if (!held.pending_valid ||
              temp_gap(r.meas_temp, held.pending) > int'(regs.stable_band)) begin
            held.pending       = r.meas_temp;
            held.pending_valid = 1'b1;
            held.pending_since = r.now_ms;
          end else begin
            elapsed = r.now_ms - held.pending_since;
            if (elapsed > regs.settle_ms) begin
              if (take_baseline(r.meas_temp)) pub = 1'b1;
            end
          end
        end else begin
          if (take_baseline(r.meas_temp)) pub = 1'b1;
        end
      end
      if (fl != held.flags) pub = 1'b1;
      held.flags = fl;
      if (!held.ever_published) pub = 1'b1;
      elapsed = r.now_ms - held.last_publish;
      if (elapsed > regs.heartbeat_ms) pub = 1'b1;
      if (pub) begin
        held.last_publish   = r.now_ms;
        held.ever_published = 1'b1;
      end
    end
    o = '0;
    o.publish           = pub;
    o.shown_set_valid   = held.target_valid;
    o.shown_target_temp = held.target_valid ? held.target : '0;
    o.shown_meas_valid  = held.baseline_valid;
    o.shown_meas_temp   = held.baseline_valid ? held.baseline : '0;
    o.shown_heating     = held.flags[0];
    o.shown_rest        = held.flags[1];
    o.shown_high_range  = held.flags[2];
    return o;
  endfunction

  function automatic in_item_t make_report(input logic link, input ms_t now,
                                           input logic sv, input temp_t st,
                                           input logic mv, input temp_t mt,
                                           input logic [2:0] fl);
    in_item_t r;
    r = '0;
    r.link_alive  = link;
    r.now_ms      = now;
    r.set_valid   = sv;
    r.target_temp = st;
    r.meas_valid  = mv;
    r.meas_temp   = mt;
    r.heater_on   = fl[0];
    r.rest_on     = fl[1];
    r.high_range  = fl[2];
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_report(input in_item_t rep);
    while (idle_on && $urandom_range(99) < 15) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = rep;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    shown_q.push_back(predict_report(rep));
    n_reports++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (shown_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_drain();
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_JUMP_THRESHOLD: regs.jump_threshold = val[LIMIT_W-1:0];
      REG_STABLE_BAND:    regs.stable_band    = val[LIMIT_W-1:0];
      REG_SETTLE_MS:      regs.settle_ms      = val;
      REG_HEARTBEAT_MS:   regs.heartbeat_ms   = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all_regs(input logic [31:0] thr, input logic [31:0] band,
                                input logic [31:0] settle, input logic [31:0] hb);
    write_reg(REG_JUMP_THRESHOLD, thr);
    write_reg(REG_STABLE_BAND, band);
    write_reg(REG_SETTLE_MS, settle);
    write_reg(REG_HEARTBEAT_MS, hb);
  endtask

  // slowly drifting temperature with jumps, spikes, link drops and noise
  task automatic run_session(input int n, input int max_step, input int noise_pct);
    in_item_t   rep;
    int         k;
    int         pick;
    int         level;
    int         mt;
    temp_t      target;
    logic [2:0] fl;
    logic       sv;
    logic       mv;
    level  = $urandom_range(3000) - 1000;
    target = temp_t'($urandom_range(3000) - 1000);
    fl     = 3'($urandom());
    for (k = 0; k < n; k++) begin
      clock_ms += ms_t'($urandom_range(max_step));
      if ($urandom_range(99) < noise_pct) begin
        rep     = {$urandom(), $urandom()};
        rep.pad = '0;
      end else begin
        pick = $urandom_range(99);
        if (pick < 3)
          level = bound_temp(level + ($urandom_range(1) ? 1 : -1) * $urandom_range(20, 400));
        if (pick >= 40 && pick < 44) target = temp_t'($urandom_range(3000) - 1000);
        if (pick >= 97) fl = 3'($urandom());
        mt = level + $urandom_range(8) - 4;
        if (pick >= 90 && pick < 95)
          mt = level + ($urandom_range(1) ? 1 : -1) * $urandom_range(100, 600);
        mt = bound_temp(mt);
        sv = ($urandom_range(99) >= 10);
        mv = ($urandom_range(99) >= 10);
        rep = make_report($urandom_range(99) >= 2, clock_ms,
                          sv, sv ? target : temp_t'($urandom()),
                          mv, mv ? temp_t'(mt) : temp_t'($urandom()), fl);
      end
      send_report(rep);
    end
  endtask

  task automatic test_first_and_target();
    clock_ms = 32'd1000;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b000));
    clock_ms += 10;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b1, 12'sd200, 1'b0, '0, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b1, 12'sd200, 1'b0, '0, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b1, 12'sd215, 1'b0, '0, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b0, 12'sd999, 1'b0, '0, 3'b000));
  endtask

  task automatic test_jump_filter();
    ms_t t0;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b1, 12'sd300, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b1, 12'sd320, 3'b000));
    t0 = clock_ms;
    send_report(make_report(1'b1, t0, 1'b0, '0, 1'b1, 12'sd500, 3'b000));
    send_report(make_report(1'b1, t0 + 30000, 1'b0, '0, 1'b1, 12'sd502, 3'b000));
    send_report(make_report(1'b1, t0 + 60000, 1'b0, '0, 1'b1, 12'sd503, 3'b000));
    send_report(make_report(1'b1, t0 + 60001, 1'b0, '0, 1'b1, 12'sd503, 3'b000));
    clock_ms = t0 + 60100;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b1, 12'sd800, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b1, 12'sd900, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b1, 12'sd530, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, 12'sd1999, 3'b000));
  endtask

  task automatic test_flags_and_heartbeat();
    ms_t t0;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b001));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b011));
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b111));
    t0 = clock_ms;
    send_report(make_report(1'b1, t0 + 300000, 1'b0, '0, 1'b0, '0, 3'b111));
    send_report(make_report(1'b1, t0 + 300001, 1'b0, '0, 1'b0, '0, 3'b111));
    send_report(make_report(1'b1, 32'hFFFF_FF00, 1'b0, '0, 1'b0, '0, 3'b111));
    clock_ms = 32'h0000_0100;
    send_report(make_report(1'b1, clock_ms, 1'b0, '0, 1'b0, '0, 3'b111));
  endtask

  task automatic test_link_down_and_extremes();
    send_report(make_report(1'b0, clock_ms, 1'b1, 12'sd777, 1'b1, 12'sd555, 3'b010));
    clock_ms += 5;
    send_report(make_report(1'b1, clock_ms, 1'b1, -12'sd2048, 1'b1, 12'sd2047, 3'b111));
    send_report(make_report(1'b1, clock_ms, 1'b1, 12'sd2047, 1'b1, -12'sd2048, 3'b111));
    send_report(make_report(1'b1, clock_ms, 1'b1, -12'sd1000, 1'b1, 12'sd2000, 3'b000));
    send_report(make_report(1'b0, clock_ms, 1'b0, '0, 1'b0, '0, 3'b000));
    send_report(make_report(1'b1, clock_ms, 1'b1, 12'sd2000, 1'b1, -12'sd1000, 3'b000));
  endtask

  task automatic test_regs_minimum();
    write_all_regs(32'd0, 32'd0, 32'd0, 32'd0);
    run_session(250, 50, 10);
  endtask

  task automatic test_regs_maximum();
    write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_session(250, 5000, 10);
  endtask

  task automatic test_unused_index_no_idle();
    write_all_regs(32'd30, 32'd8, 32'd200, 32'd1500);
    write_reg(REG_UNUSED_LO, $urandom());
    write_reg(REG_UNUSED_HI, $urandom());
    idle_on = 1'b0;
    run_session(500, 60, 8);
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_reset_values();
    write_all_regs(32'(JUMP_THRESHOLD_RST), 32'(STABLE_BAND_RST), SETTLE_MS_RST,
                   HEARTBEAT_MS_RST);
    run_session(400, 20000, 8);
  endtask

  task automatic test_random_regs();
    int k;
    for (k = 0; k < 3; k++) begin
      // upper bits carry garbage that the narrow registers must drop
      write_all_regs(($urandom() & ~32'h7FF) | 32'($urandom_range(200)),
                     ($urandom() & ~32'h7FF) | 32'($urandom_range(20)),
                     32'($urandom_range(5000)), 32'($urandom_range(20000)));
      run_session(100, 400, 10);
    end
  endtask

  task automatic test_noise();
    run_session(200, 1000, 100);
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (shown_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", m_axis_tdata);
      end else begin
        want = shown_q.pop_front();
        if (want.publish) n_published++;
        if (m_axis_tdata.publish           !== want.publish ||
            m_axis_tdata.shown_set_valid   !== want.shown_set_valid ||
            m_axis_tdata.shown_target_temp !== want.shown_target_temp ||
            m_axis_tdata.shown_meas_valid  !== want.shown_meas_valid ||
            m_axis_tdata.shown_meas_temp   !== want.shown_meas_temp ||
            m_axis_tdata.shown_heating     !== want.shown_heating ||
            m_axis_tdata.shown_rest        !== want.shown_rest ||
            m_axis_tdata.shown_high_range  !== want.shown_high_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p, got %p",
                     n_results, want, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    regs.jump_threshold = JUMP_THRESHOLD_RST;
    regs.stable_band    = STABLE_BAND_RST;
    regs.settle_ms      = SETTLE_MS_RST;
    regs.heartbeat_ms   = HEARTBEAT_MS_RST;
    held = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_first_and_target();
    test_jump_filter();
    test_flags_and_heartbeat();
    test_link_down_and_extremes();
    test_regs_minimum();
    test_regs_maximum();
    test_unused_index_no_idle();
    test_reset_values();
    test_random_regs();
    test_noise();
    wait_drain();

    $display("Sent %0d reports, checked %0d results (%0d published), %0d register writes.",
             n_reports, n_results, n_published, n_writes);
    $display("Settings covered reset, all-zero, all-ones, mid and random values; %s",
             "link drops, jumps, spikes, wrap and noise.");
    if (mismatches == 0 && shown_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, shown_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tjf_pkg.sv
hdl/tjf_decide.sv
hdl/temp_jump_filter_with_publish.sv
sim/temp_jump_filter_with_publish_tb.sv
